[hdl/frx_pkg.sv]
// shared types, constants and the crc-8 step function for the frame receiver
// no dependencies; used by every frx module and by the top level
`default_nettype none

package frx_pkg;

  localparam int COUNTER_WIDTH_DEF = 32;

  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int STAT_W      = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_END_BYTE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 2'd2;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h02;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h03;
  localparam logic [BYTE_W-1:0] MAX_LENGTH_RST = 8'hFF;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_CRC     = 5'b01000,
    PH_END     = 5'b10000
  } frx_phase_t;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_GOOD = 3'd1,
    EV_CRC  = 3'd2,
    EV_LEN  = 3'd3,
    EV_END  = 3'd4
  } frx_event_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [BYTE_W-1:0] max_length;
  } frx_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
    frx_event_t        frame_event;
    logic [BYTE_W-1:0] frame_length;
    logic [STAT_W-1:0] good_frames;
    logic [STAT_W-1:0] crc_errors;
  } frx_result_t;

  // msb-first crc-8, one byte per call
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/frx_in_stage.sv]
// input register of the frame receiver: holds one received byte
// depends on frx_pkg for the byte width
`default_nettype none

module frx_in_stage (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      item_valid,
  output logic                           item_stall,
  input  wire logic [frx_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic                      down_ready,
  output logic                           held_valid,
  output logic [frx_pkg::BYTE_W-1:0]     held_byte,
  output logic                           advance
);

  logic take;

  assign advance    = held_valid && down_ready;
  assign item_stall = held_valid && !down_ready;
  assign take       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_byte <= rx_byte;
    end
  end

endmodule

`default_nettype wire

[hdl/frx_parser.sv]
// frame parser: phase, length, crc and counter state plus the per-byte result
// depends on frx_pkg for types, codes and the crc-8 function
`default_nettype none

module frx_parser #(
  parameter int COUNTER_WIDTH = frx_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire logic [frx_pkg::BYTE_W-1:0] b,
  input  wire frx_pkg::frx_cfg_t         cfg,
  output frx_pkg::frx_result_t           result
);

  frx_pkg::frx_phase_t          phase, phase_next;
  logic [frx_pkg::BYTE_W-1:0]   bytes_taken, bytes_taken_next;
  logic [frx_pkg::BYTE_W-1:0]   expected_length, expected_length_next;
  logic [frx_pkg::BYTE_W-1:0]   running_crc, running_crc_next;
  logic [COUNTER_WIDTH-1:0]     good_cnt, good_cnt_next;
  logic [COUNTER_WIDTH-1:0]     crc_cnt, crc_cnt_next;
  logic [frx_pkg::BYTE_W-1:0]   taken_inc;

  assign taken_inc = bytes_taken + 8'd1;

  always_comb begin
    phase_next           = phase;
    bytes_taken_next     = bytes_taken;
    expected_length_next = expected_length;
    running_crc_next     = running_crc;
    good_cnt_next        = good_cnt;
    crc_cnt_next         = crc_cnt;
    result.payload_byte  = '0;
    result.payload_valid = 1'b0;
    result.frame_event   = frx_pkg::EV_NONE;
    result.frame_length  = '0;
    unique case (phase)
      frx_pkg::PH_IDLE: begin
        if (b == cfg.start_byte) begin
          phase_next       = frx_pkg::PH_LEN;
          bytes_taken_next = '0;
          running_crc_next = frx_pkg::CRC_INIT;
        end
      end
      frx_pkg::PH_LEN: begin
        expected_length_next = b;
        bytes_taken_next     = '0;
        running_crc_next     = frx_pkg::CRC_INIT;
        if (b == '0 || b > cfg.max_length) begin
          result.frame_event  = frx_pkg::EV_LEN;
          result.frame_length = b;
          phase_next          = frx_pkg::PH_IDLE;
        end else begin
          phase_next = frx_pkg::PH_PAYLOAD;
        end
      end
      frx_pkg::PH_PAYLOAD: begin
        result.payload_byte  = b;
        result.payload_valid = 1'b1;
        running_crc_next     = frx_pkg::crc8_update(running_crc, b);
        bytes_taken_next     = taken_inc;
        if (taken_inc >= expected_length) begin
          phase_next = frx_pkg::PH_CRC;
        end
      end
      frx_pkg::PH_CRC: begin
        if (b == running_crc) begin
          phase_next = frx_pkg::PH_END;
        end else begin
          crc_cnt_next        = crc_cnt + 1'b1;
          result.frame_event  = frx_pkg::EV_CRC;
          result.frame_length = expected_length;
          phase_next          = frx_pkg::PH_IDLE;
        end
      end
      frx_pkg::PH_END: begin
        if (b == cfg.end_byte) begin
          good_cnt_next      = good_cnt + 1'b1;
          result.frame_event = frx_pkg::EV_GOOD;
        end else begin
          result.frame_event = frx_pkg::EV_END;
        end
        result.frame_length = expected_length;
        phase_next          = frx_pkg::PH_IDLE;
      end
      default: begin
        phase_next       = frx_pkg::PH_IDLE;
        bytes_taken_next = '0;
        running_crc_next = frx_pkg::CRC_INIT;
      end
    endcase
    result.good_frames = frx_pkg::STAT_W'(good_cnt_next);
    result.crc_errors  = frx_pkg::STAT_W'(crc_cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= frx_pkg::PH_IDLE;
      bytes_taken     <= '0;
      expected_length <= '0;
      running_crc     <= frx_pkg::CRC_INIT;
      good_cnt        <= '0;
      crc_cnt         <= '0;
    end else if (step) begin
      phase           <= phase_next;
      bytes_taken     <= bytes_taken_next;
      expected_length <= expected_length_next;
      running_crc     <= running_crc_next;
      good_cnt        <= good_cnt_next;
      crc_cnt         <= crc_cnt_next;
    end
  end

  a_good_count_steps: assert property (@(posedge clk) disable iff (rst)
    step && result.frame_event == frx_pkg::EV_GOOD |=> good_cnt == $past(good_cnt) + 1'b1)
    else $error("good frame counter did not advance on a good frame");

  a_counts_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(good_cnt) && $stable(crc_cnt) && $stable(phase))
    else $error("parser state changed without a request");

  a_payload_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == frx_pkg::PH_PAYLOAD |-> expected_length != '0)
    else $error("payload phase with zero frame length");

  a_crc_err_to_idle: assert property (@(posedge clk) disable iff (rst)
    step && result.frame_event == frx_pkg::EV_CRC
      |=> phase == frx_pkg::PH_IDLE && crc_cnt == $past(crc_cnt) + 1'b1)
    else $error("crc error not followed by idle and count");

endmodule

`default_nettype wire

[hdl/frx_out_stage.sv]
// result register of the frame receiver with valid and stall toward the sink
// depends on frx_pkg for the result struct
`default_nettype none

module frx_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire frx_pkg::frx_result_t result_in,
  output logic                      ready,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output frx_pkg::frx_result_t      result_q
);

  assign ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      result_q <= result_in;
    end
  end

endmodule

`default_nettype wire

[hdl/stx_len_crc8_etx_frame_receiver.sv]
// Frame receiver for start/length/payload/crc-8/end framed byte streams.
// One received byte is taken per cycle while item_stall is low and gives one result: the byte
// is held in an input register, parsed by combinational logic (phase, length check,
// crc-8 with polynomial 0x31, counters) and captured in a result register. A stall
// from the result side reaches item_stall in the same cycle once the input register
// is occupied. Configuration writes through cfg_write/cfg_index/cfg_data take effect
// from the next parsed byte; indexes beyond the register list are ignored.
// Depends on frx_pkg, frx_in_stage, frx_parser and frx_out_stage.
`default_nettype none

module stx_len_crc8_etx_frame_receiver #(
  parameter int COUNTER_WIDTH = frx_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire logic [frx_pkg::BYTE_W-1:0]     rx_byte,
  input  wire logic                           cfg_write,
  input  wire logic [frx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [frx_pkg::BYTE_W-1:0]     cfg_data,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic [frx_pkg::BYTE_W-1:0]          payload_byte,
  output logic                                payload_valid,
  output logic [2:0]                          frame_event,
  output logic [frx_pkg::BYTE_W-1:0]          frame_length,
  output logic [frx_pkg::STAT_W-1:0]          good_frames,
  output logic [frx_pkg::STAT_W-1:0]          crc_errors
);

  frx_pkg::frx_cfg_t            cfg;
  frx_pkg::frx_result_t         parse_result;
  frx_pkg::frx_result_t         result_q;
  logic                         held_valid;
  logic [frx_pkg::BYTE_W-1:0]   held_byte;
  logic                         advance;
  logic                         out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte <= frx_pkg::START_BYTE_RST;
      cfg.end_byte   <= frx_pkg::END_BYTE_RST;
      cfg.max_length <= frx_pkg::MAX_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        frx_pkg::CFG_START_BYTE: cfg.start_byte <= cfg_data;
        frx_pkg::CFG_END_BYTE:   cfg.end_byte   <= cfg_data;
        frx_pkg::CFG_MAX_LENGTH: cfg.max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  frx_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .rx_byte    (rx_byte),
    .down_ready (out_ready),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .advance    (advance)
  );

  frx_parser #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .b      (held_byte),
    .cfg    (cfg),
    .result (parse_result)
  );

  frx_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (held_valid),
    .result_in    (parse_result),
    .ready        (out_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_q     (result_q)
  );

  assign payload_byte  = result_q.payload_byte;
  assign payload_valid = result_q.payload_valid;
  assign frame_event   = result_q.frame_event;
  assign frame_length  = result_q.frame_length;
  assign good_frames   = result_q.good_frames;
  assign crc_errors    = result_q.crc_errors;

endmodule

`default_nettype wire

[tb/tb.sv]
// self-checking testbench for stx_len_crc8_etx_frame_receiver: byte stream in, one result per byte
// depends on frx_pkg and the receiver rtl; a byte-level frame parser predicts every result
`timescale 1ns / 100ps

class rx_frame_track;
  logic [7:0]           start_val;
  logic [7:0]           end_val;
  logic [7:0]           max_val;
  frx_pkg::frx_phase_t  phase;
  logic [7:0]           taken;
  logic [7:0]           frame_len;
  logic [7:0]           crc;
  logic [31:0]          good_count;
  logic [31:0]          crc_count;
  frx_pkg::frx_result_t results_due[$];
  int                   errors;

  function new();
    start_val  = frx_pkg::START_BYTE_RST;
    end_val    = frx_pkg::END_BYTE_RST;
    max_val    = frx_pkg::MAX_LENGTH_RST;
    phase      = frx_pkg::PH_IDLE;
    taken      = '0;
    frame_len  = '0;
    crc        = frx_pkg::CRC_INIT;
    good_count = '0;
    crc_count  = '0;
    errors     = 0;
  endfunction

  // bit-serial form, one message bit per shift
  static function logic [7:0] crc8_next(logic [7:0] c_in, logic [7:0] b);
    logic [7:0] c;
    c = c_in;
    for (int i = 7; i >= 0; i--) begin
      if (c[7] ^ b[i]) begin
        c = {c[6:0], 1'b0} ^ frx_pkg::CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function void set_reg(logic [1:0] idx, logic [7:0] v);
    unique case (idx)
      frx_pkg::CFG_START_BYTE: start_val = v;
      frx_pkg::CFG_END_BYTE:   end_val = v;
      frx_pkg::CFG_MAX_LENGTH: max_val = v;
      default: ;
    endcase
  endfunction

  function void take_byte(logic [7:0] b);
    frx_pkg::frx_result_t r;
    r = '0;
    unique case (phase)
      frx_pkg::PH_IDLE: begin
        if (b == start_val) begin
          phase = frx_pkg::PH_LEN;
          taken = '0;
          crc   = frx_pkg::CRC_INIT;
        end
      end
      frx_pkg::PH_LEN: begin
        frame_len = b;
        taken     = '0;
        crc       = frx_pkg::CRC_INIT;
        if (b == 8'd0 || b > max_val) begin
          r.frame_event  = frx_pkg::EV_LEN;
          r.frame_length = b;
          phase          = frx_pkg::PH_IDLE;
        end else begin
          phase = frx_pkg::PH_PAYLOAD;
        end
      end
      frx_pkg::PH_PAYLOAD: begin
        r.payload_byte  = b;
        r.payload_valid = 1'b1;
        crc   = crc8_next(crc, b);
        taken = taken + 8'd1;
        if (taken >= frame_len) phase = frx_pkg::PH_CRC;
      end
      frx_pkg::PH_CRC: begin
        if (b == crc) begin
          phase = frx_pkg::PH_END;
        end else begin
          crc_count      = crc_count + 32'd1;
          r.frame_event  = frx_pkg::EV_CRC;
          r.frame_length = frame_len;
          phase          = frx_pkg::PH_IDLE;
        end
      end
      frx_pkg::PH_END: begin
        if (b == end_val) begin
          good_count    = good_count + 32'd1;
          r.frame_event = frx_pkg::EV_GOOD;
        end else begin
          r.frame_event = frx_pkg::EV_END;
        end
        r.frame_length = frame_len;
        phase          = frx_pkg::PH_IDLE;
      end
      default: begin
        phase = frx_pkg::PH_IDLE;
        taken = '0;
        crc   = frx_pkg::CRC_INIT;
      end
    endcase
    r.good_frames = good_count;
    r.crc_errors  = crc_count;
    results_due.push_back(r);
  endfunction

  function void diff(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void match_result(frx_pkg::frx_result_t got);
    frx_pkg::frx_result_t want;
    if (results_due.size() == 0) begin
      $display("%0t unexpected result: expected none actual event %0d", $time,
               got.frame_event);
      errors++;
      return;
    end
    want = results_due.pop_front();
    diff("payload_byte", want.payload_byte, got.payload_byte);
    diff("payload_valid", want.payload_valid, got.payload_valid);
    diff("frame_event", want.frame_event, got.frame_event);
    diff("frame_length", want.frame_length, got.frame_length);
    diff("good_frames", want.good_frames, got.good_frames);
    diff("crc_errors", want.crc_errors, got.crc_errors);
  endfunction
endclass

module tb;

  localparam logic [frx_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
  localparam int WATCHDOG = 2000;

  typedef enum int {
    FK_GOOD,
    FK_BAD_CRC,
    FK_BAD_END,
    FK_ZERO_LEN,
    FK_LONG_LEN,
    FK_CUT,
    FK_NOISE
  } frame_kind_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [7:0]  rx_byte = '0;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic [2:0]  frame_event;
  logic [7:0]  frame_length;
  logic [31:0] good_frames;
  logic [31:0] crc_errors;

  rx_frame_track        trk = new();
  frx_pkg::frx_result_t got_r;
  bit                   calm = 1'b0;
  int                   sent = 0;
  int                   quiet = 0;

  stx_len_crc8_etx_frame_receiver DUT (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .rx_byte       (rx_byte),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .payload_byte  (payload_byte),
    .payload_valid (payload_valid),
    .frame_event   (frame_event),
    .frame_length  (frame_length),
    .good_frames   (good_frames),
    .crc_errors    (crc_errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // one request per rx byte
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 19) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    rx_byte    <= b;
    do @(posedge clk); while (item_stall);
    trk.take_byte(b);
    sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    item_valid <= 1'b0;
    while (trk.results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    trk.set_reg(idx, val);
  endtask

  // pat < 0 gives random payload, else every payload byte is pat
  task automatic send_frame(input frame_kind_t kind, input int len, input int pat);
    logic [7:0] crc;
    logic [7:0] b;
    logic [7:0] mx;
    int         n;
    crc = frx_pkg::CRC_INIT;
    mx  = trk.max_val;
    if (kind == FK_NOISE) begin
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      return;
    end
    send_byte(trk.start_val);
    if (kind == FK_ZERO_LEN) begin
      send_byte(8'h00);
      return;
    end
    if (kind == FK_LONG_LEN) begin
      send_byte((mx == 8'hFF) ? 8'h00 : 8'($urandom_range(255, mx + 1)));
      return;
    end
    send_byte(8'(len));
    n = (kind == FK_CUT) ? $urandom_range(len - 1, 0) : len;
    for (int i = 0; i < n; i++) begin
      b   = (pat < 0) ? 8'($urandom_range(255)) : 8'(pat);
      crc = frx_pkg::crc8_update(crc, b);
      send_byte(b);
    end
    if (kind == FK_CUT) return;
    send_byte((kind == FK_BAD_CRC) ? (crc ^ 8'($urandom_range(255, 1))) : crc);
    if (kind == FK_BAD_CRC) return;
    send_byte((kind == FK_BAD_END) ? (trk.end_val ^ 8'($urandom_range(255, 1))) : trk.end_val);
  endtask

  task automatic run_phase(input int quota);
    int          stop;
    int          pick;
    int          lim;
    int          len;
    frame_kind_t k;
    stop = sent + quota;
    while (sent < stop) begin
      // realign after a cut frame
      while (trk.phase != frx_pkg::PH_IDLE) send_byte(8'($urandom_range(255)));
      pick = $urandom_range(99);
      lim  = (trk.max_val > 8) ? 8 : trk.max_val;
      if (trk.max_val == 8'd0) k = (pick < 50) ? FK_ZERO_LEN : FK_LONG_LEN;
      else if (pick < 60) k = FK_GOOD;
      else if (pick < 70) k = FK_BAD_CRC;
      else if (pick < 80) k = FK_BAD_END;
      else if (pick < 85) k = FK_ZERO_LEN;
      else if (pick < 90) k = FK_LONG_LEN;
      else if (pick < 95) k = FK_CUT;
      else k = FK_NOISE;
      if (trk.max_val == 8'd0) len = 1;
      else if ($urandom_range(39) == 0) len = $urandom_range(trk.max_val, 1);
      else len = $urandom_range(lim, 1);
      send_frame(k, len, -1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      got_r.payload_byte  = payload_byte;
      got_r.payload_valid = payload_valid;
      got_r.frame_event   = frx_pkg::frx_event_t'(frame_event);
      got_r.frame_length  = frame_length;
      got_r.good_frames   = good_frames;
      got_r.crc_errors    = crc_errors;
      trk.match_result(got_r);
    end
    result_stall <= !calm && ($urandom_range(99) < 19);
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet = 0;
    else quiet = quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle noise, then start byte as payload, crc and end faults, zero length
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h03);
    send_frame(FK_GOOD, 1, 2);
    send_frame(FK_GOOD, 1, 255);
    send_frame(FK_BAD_CRC, 1, 0);
    send_frame(FK_BAD_END, 1, 0);
    send_frame(FK_ZERO_LEN, 1, -1);
    write_reg(frx_pkg::CFG_MAX_LENGTH, 8'd1);
    send_frame(FK_LONG_LEN, 1, -1);
    send_frame(FK_GOOD, 1, -1);

    calm = 1'b1;
    write_reg(frx_pkg::CFG_START_BYTE, 8'h7E);
    write_reg(frx_pkg::CFG_END_BYTE, 8'h7F);
    write_reg(frx_pkg::CFG_MAX_LENGTH, 8'd16);
    run_phase(200);
    calm = 1'b0;

    write_reg(frx_pkg::CFG_START_BYTE, 8'h00);
    write_reg(frx_pkg::CFG_END_BYTE, 8'hFF);
    write_reg(frx_pkg::CFG_MAX_LENGTH, 8'hFF);
    send_frame(FK_GOOD, 255, -1);
    run_phase(150);

    write_reg(frx_pkg::CFG_START_BYTE, 8'hFF);
    write_reg(frx_pkg::CFG_END_BYTE, 8'h00);
    write_reg(frx_pkg::CFG_MAX_LENGTH, 8'd1);
    run_phase(120);

    write_reg(frx_pkg::CFG_MAX_LENGTH, 8'd0);
    write_reg(CFG_SPARE, 8'($urandom_range(255)));
    run_phase(60);

    repeat (5) begin
      write_reg(frx_pkg::CFG_START_BYTE, 8'($urandom_range(255)));
      write_reg(frx_pkg::CFG_END_BYTE, 8'($urandom_range(255)));
      write_reg(frx_pkg::CFG_MAX_LENGTH, 8'($urandom_range(255, 1)));
      if ($urandom_range(1) == 0) write_reg(CFG_SPARE, 8'($urandom_range(255)));
      run_phase(130);
    end

    item_valid <= 1'b0;
    while (trk.results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (trk.errors == 0 && trk.results_due.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hdl/frx_pkg.sv
hdl/frx_in_stage.sv
hdl/frx_parser.sv
hdl/frx_out_stage.sv
hdl/stx_len_crc8_etx_frame_receiver.sv
tb/tb.sv
